/* rtl/mlbd_pkg.sv */
// ============================================================================
// mlbd_pkg: shared types and constants of the mip level box downsampler
// Sizes of the level, the line store and the command queue between the
// front and back parts, and the command that travels through that queue.
// ============================================================================
package mlbd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CHAN_W    = 8;
    localparam int PAIR_W    = CHAN_W + 1;
    localparam int QUAD_W    = PAIR_W + 1;
    localparam int NUM_CHAN  = 4;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CMP_W_A = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int CMP_W   = (ROW_W + 1 > CMP_W_A) ? ROW_W + 1 : CMP_W_A;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_IDX_W = COL_W - 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd2;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_pixel;
    typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] t_pair;

    typedef enum logic {
        CMD_WRITE,
        CMD_READ
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op               op;
        logic [LINE_IDX_W-1:0] idx;
        t_pair                 pair;
        logic                  last;
    } t_cmd;

endpackage

/* rtl/mlbd_if.sv */
// ============================================================================
// mlbd_if: channel interfaces of the mip level box downsampler
// Pixel input, reduced pixel output and configuration write channels.
// ============================================================================
interface mlbd_pix_if;
    logic                        valid;
    logic                        ready;
    logic [mlbd_pkg::CHAN_W-1:0] red_in;
    logic [mlbd_pkg::CHAN_W-1:0] green_in;
    logic [mlbd_pkg::CHAN_W-1:0] blue_in;
    logic [mlbd_pkg::CHAN_W-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mlbd_res_if;
    logic                        valid;
    logic                        ready;
    logic [mlbd_pkg::CHAN_W-1:0] red_out;
    logic [mlbd_pkg::CHAN_W-1:0] green_out;
    logic [mlbd_pkg::CHAN_W-1:0] blue_out;
    logic [mlbd_pkg::CHAN_W-1:0] alpha_out;
    logic                        last_of_level;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, last_of_level,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out, last_of_level,
                  output ready);
endinterface

interface mlbd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mlbd_pkg::CFG_IDX_W-1:0] index;
    logic [mlbd_pkg::DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mlbd_front.sv */
// ============================================================================
// mlbd_front: pixel intake and classification
// Holds the level size and the pixel position, forms horizontal pair sums
// and issues a line write or a line read command for every odd column.
// ============================================================================
module mlbd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mlbd_pix_if.sink       i_pix,
    mlbd_cfg_if.sink       i_cfg,
    output logic           o_push,
    output mlbd_pkg::t_cmd o_cmd,
    input  logic           i_push_ready
);

    logic [mlbd_pkg::DIM_W-1:0] r_level_width;
    logic [mlbd_pkg::DIM_W-1:0] r_level_height;
    logic [mlbd_pkg::COL_W-1:0] r_col;
    logic [mlbd_pkg::COL_W-1:0] n_col;
    logic [mlbd_pkg::ROW_W-1:0] r_row;
    logic [mlbd_pkg::ROW_W-1:0] n_row;
    mlbd_pkg::t_pixel           r_pending;

    logic                       w_accept;
    mlbd_pkg::t_pixel           w_px;
    logic [mlbd_pkg::CMP_W-1:0] w_width;
    logic [mlbd_pkg::CMP_W-1:0] w_height;
    logic [mlbd_pkg::CMP_W-1:0] w_col_ext;
    logic [mlbd_pkg::CMP_W-1:0] w_row_ext;
    logic [mlbd_pkg::CMP_W-1:0] w_last_col;
    logic [mlbd_pkg::CMP_W-1:0] w_last_row;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = i_push_ready;
    assign w_accept    = i_pix.valid && i_pix.ready;

    assign w_px = {i_pix.alpha_in, i_pix.blue_in, i_pix.green_in, i_pix.red_in};

    always_comb begin
        w_width  = mlbd_pkg::CMP_W'(r_level_width);
        w_height = mlbd_pkg::CMP_W'(r_level_height);
        if (w_width < mlbd_pkg::CMP_W'(2)) begin
            w_width = mlbd_pkg::CMP_W'(2);
        end else if (w_width > mlbd_pkg::CMP_W'(mlbd_pkg::MAX_WIDTH)) begin
            w_width = mlbd_pkg::CMP_W'(mlbd_pkg::MAX_WIDTH);
        end
        if (w_height < mlbd_pkg::CMP_W'(2)) begin
            w_height = mlbd_pkg::CMP_W'(2);
        end else if (w_height > mlbd_pkg::CMP_W'(mlbd_pkg::MAX_HEIGHT)) begin
            w_height = mlbd_pkg::CMP_W'(mlbd_pkg::MAX_HEIGHT);
        end
    end

    assign w_col_ext  = mlbd_pkg::CMP_W'(r_col);
    assign w_row_ext  = mlbd_pkg::CMP_W'(r_row);
    assign w_last_col = {w_width[mlbd_pkg::CMP_W-1:1], 1'b0} - mlbd_pkg::CMP_W'(1);
    assign w_last_row = {w_height[mlbd_pkg::CMP_W-1:1], 1'b0} - mlbd_pkg::CMP_W'(1);

    always_comb begin
        o_push     = w_accept && r_col[0];
        o_cmd.op   = r_row[0] ? mlbd_pkg::CMD_READ : mlbd_pkg::CMD_WRITE;
        o_cmd.idx  = r_col[mlbd_pkg::COL_W-1:1];
        o_cmd.last = (w_col_ext == w_last_col) && (w_row_ext == w_last_row);
        for (int i = 0; i < mlbd_pkg::NUM_CHAN; i++) begin
            o_cmd.pair[i] = {1'b0, r_pending[i]} + {1'b0, w_px[i]};
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_col_ext + mlbd_pkg::CMP_W'(1) >= w_width) begin
            n_col = '0;
            if (w_row_ext + mlbd_pkg::CMP_W'(1) >= w_height) begin
                n_row = '0;
            end else begin
                n_row = r_row + mlbd_pkg::ROW_W'(1);
            end
        end else begin
            n_col = r_col + mlbd_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_width  <= mlbd_pkg::DIM_RESET;
            r_level_height <= mlbd_pkg::DIM_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_pending      <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    mlbd_pkg::CFG_LEVEL_WIDTH: begin
                        r_level_width <= i_cfg.data;
                    end
                    mlbd_pkg::CFG_LEVEL_HEIGHT: begin
                        r_level_height <= i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
                if (!r_col[0]) begin
                    r_pending <= w_px;
                end
            end
        end
    end

endmodule

/* rtl/mlbd_queue.sv */
// ============================================================================
// mlbd_queue: command queue between the front and back parts
// A short first-in first-out buffer so that either side can stall alone.
// ============================================================================
module mlbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mlbd_pkg::t_cmd i_cmd,
    output logic           o_push_ready,
    output logic           o_valid,
    output mlbd_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    mlbd_pkg::t_cmd                   r_mem [mlbd_pkg::QUEUE_DEPTH];
    logic [mlbd_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [mlbd_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [mlbd_pkg::QUEUE_CNT_W-1:0] r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_push_ready = r_count != mlbd_pkg::QUEUE_CNT_W'(mlbd_pkg::QUEUE_DEPTH);
    assign o_valid      = r_count != '0;
    assign o_cmd        = r_mem[r_rd_ptr];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + mlbd_pkg::QUEUE_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + mlbd_pkg::QUEUE_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + mlbd_pkg::QUEUE_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - mlbd_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/mlbd_back.sv */
// ============================================================================
// mlbd_back: line store and block reduction
// Writes pair sums of even rows into the line store, reads them back for
// odd rows and forms the truncated mean in a held output register.
// ============================================================================
module mlbd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mlbd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    mlbd_res_if.source     o_res
);

    mlbd_pkg::t_pair r_line [mlbd_pkg::LINE_DEPTH];
    mlbd_pkg::t_pair r_rd_data;
    mlbd_pkg::t_pair r_s1_pair;
    logic            r_s1_last;
    logic            r_s1_valid;
    logic            r_out_valid;
    logic            r_out_last;
    mlbd_pkg::t_pixel r_out_px;
    mlbd_pkg::t_pixel w_mean;

    logic w_s1_move;
    logic w_s1_load;
    logic w_wr_en;
    logic w_rd_en;

    logic [mlbd_pkg::QUAD_W-1:0] w_sum [mlbd_pkg::NUM_CHAN];

    assign w_s1_move = r_s1_valid && (!r_out_valid || o_res.ready);
    assign w_s1_load = !r_s1_valid || w_s1_move;

    always_comb begin
        w_wr_en = 1'b0;
        w_rd_en = 1'b0;
        if (i_valid) begin
            unique case (i_cmd.op)
                mlbd_pkg::CMD_WRITE: begin
                    w_wr_en = 1'b1;
                end
                mlbd_pkg::CMD_READ: begin
                    w_rd_en = w_s1_load;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_pop = w_wr_en || w_rd_en;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_line[i_cmd.idx] <= i_cmd.pair;
        end
        if (w_rd_en) begin
            r_rd_data <= r_line[i_cmd.idx];
        end
    end

    always_comb begin
        for (int i = 0; i < mlbd_pkg::NUM_CHAN; i++) begin
            w_sum[i]  = {1'b0, r_rd_data[i]} + {1'b0, r_s1_pair[i]};
            w_mean[i] = w_sum[i][mlbd_pkg::QUAD_W-1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_s1_pair <= i_cmd.pair;
            r_s1_last <= i_cmd.last;
        end
        if (w_s1_move) begin
            r_out_px   <= w_mean;
            r_out_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= w_rd_en;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.red_out       = r_out_px[0];
    assign o_res.green_out     = r_out_px[1];
    assign o_res.blue_out      = r_out_px[2];
    assign o_res.alpha_out     = r_out_px[3];
    assign o_res.last_of_level = r_out_last;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |=> (r_s1_valid && $stable(r_rd_data)))
        else $error("Read stage lost its data while the output was stalled.");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> r_out_valid)
        else $error("A reduced pixel left the read stage but did not reach the output.");

    a_no_read_on_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |-> !w_rd_en)
        else $error("A line read was issued while the read stage was occupied.");

endmodule

/* rtl/mip_level_box_downsample.sv */
// ============================================================================
// mip_level_box_downsample: 2x2 box filter reduction of an RGBA8 mip level
// Pixels enter in row-major order on the pixel channel; one reduced pixel
// leaves on the result channel for each complete 2x2 block.
//
// The configuration channel writes the level width (index 0) and height
// (index 1); it is always ready and is meant to be written while idle.
// Values outside 2 to 1024 are saturated into that range.
// A level streams at one pixel per cycle while the command queue has room.
// A block's result passes from the beat of its bottom-right pixel through
// the command queue, the registered line store read and the output register,
// in that order. Odd last columns and rows are consumed and give no result.
// The final result of a level carries last_of_level, and the position
// counters then restart at the top left.
// When the receiver stalls, the output register and the read stage hold;
// the two-entry command queue fills and the pixel channel drops ready.
// Reset clears the position, the level size (back to 2 by 2) and all valid
// flags; the line store holds no reset value and needs no clearing pass.
// ============================================================================
module mip_level_box_downsample (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlbd_pix_if.sink    i_pix,
    mlbd_cfg_if.sink    i_cfg,
    mlbd_res_if.source  o_res
);

    logic           w_push;
    logic           w_push_ready;
    mlbd_pkg::t_cmd w_push_cmd;
    logic           w_q_valid;
    mlbd_pkg::t_cmd w_q_cmd;
    logic           w_pop;

    mlbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_cfg        (i_cfg),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd),
        .i_push_ready (w_push_ready)
    );

    mlbd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_valid      (w_q_valid),
        .o_cmd        (w_q_cmd),
        .i_pop        (w_pop)
    );

    mlbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
